// ----- rtl/core/diff_token_merger_top_defines.svh -----
// Assertion macros for the diff token merger.
// DTM_ASSERT_IMPL: cond_a in a cycle implies cond_c in the same cycle.
// DTM_ASSERT_NEXT: cond_a in a cycle implies cond_c in the next cycle.
`ifndef DIFF_TOKEN_MERGER_TOP_DEFINES_SVH
`define DIFF_TOKEN_MERGER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define DTM_ASSERT_IMPL(lbl, cond_a, cond_c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_c)) \
        else $error(msg);
`define DTM_ASSERT_NEXT(lbl, cond_a, cond_c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_c)) \
        else $error(msg);
`else
`define DTM_ASSERT_IMPL(lbl, cond_a, cond_c, msg)
`define DTM_ASSERT_NEXT(lbl, cond_a, cond_c, msg)
`endif
`endif

// ----- rtl/core/dtm_pkg.sv -----
package dtm_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // token type codes (top two bits of a byte)
    localparam logic [1:0] TOK_SKIP    = 2'b00;
    localparam logic [1:0] TOK_INVALID = 2'b01;
    localparam logic [1:0] TOK_SINGLE  = 2'b10;
    localparam logic [1:0] TOK_PACKED  = 2'b11;

    typedef struct packed {
        logic [7:0] diff_byte;
        logic       end_of_list;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_word_t;

    // one merge decision: up to four output bytes
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            last;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

// ----- rtl/core/diff_token_merger_top.sv -----
// Diff token merger: takes a diff token byte list one word per cycle while the
// queue has room, and emits the merged list one word per cycle unless stalled.
// src channel: src_word.diff_byte plus src_word.end_of_list on the final byte.
//   A word moves when src_valid is high and src_stall is low.
// dst channel: dst_word.out_byte, with dst_word.out_last on the final byte of
//   the list; dst_stall from the receiver holds the word in place.
// The front keeps a four-byte window and makes one merge decision per input
// word (three singles -> one packed byte, two small skips -> one skip, invalid
// bytes dropped); a flush word sends the leftover window behind the decision.
// Each decision (1 to 4 output bytes) goes into a 4-entry queue; the back
// serializes the queue head into the output register, one byte per cycle unless stalled.
// An accepted byte goes through the queue and then the output register before it leaves.
// Throughput: one input word per cycle while the queue has room; the output
// port moves one byte per cycle unless stalled, so lists that merge little (unmerged skips,
// flushes) are paced by the output side and src_stall rises when the queue fills.
// Reset clears the window, the queue and the output register; a new list may
// start right after a word marked end_of_list.
module diff_token_merger_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  dtm_pkg::in_word_t  src_word,
    output logic               dst_valid,
    input  logic               dst_stall,
    output dtm_pkg::out_word_t dst_word
);
    import dtm_pkg::*;

    `include "diff_token_merger_top_defines.svh"

    logic    accept;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    cmd_t    f_cmd;
    q_head_t q_head;

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;

    dtm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (src_word),
        .cmd    (f_cmd),
        .push   (q_push)
    );

    dtm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (f_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full)
    );

    dtm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .pop       (q_pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word)
    );

    // a flush always has at least one byte to send
    `DTM_ASSERT_IMPL(a_flush_pushes, accept && src_word.end_of_list, q_push, "flush lost")
    // the back never pops an empty queue
    `DTM_ASSERT_IMPL(a_pop_valid, q_pop, q_head.valid, "pop of empty queue")
    // a decision never carries more than four bytes
    `DTM_ASSERT_IMPL(a_cnt_range, q_push, f_cmd.cnt <= 3'd4, "decision too long")

endmodule

// ----- rtl/core/dtm_front.sv -----
module dtm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  dtm_pkg::in_word_t word,
    output dtm_pkg::cmd_t    cmd,
    output logic             push
);
    import dtm_pkg::*;

    logic [7:0] win_reg [0:2];
    logic [1:0] cnt_reg;

    logic [7:0] w   [0:3];
    logic [7:0] d   [0:1];
    logic [7:0] rem [0:2];
    logic [1:0] dcnt;
    logic [2:0] used;
    logic [2:0] total;
    logic [2:0] remn;
    logic [15:0] skip_sum;
    logic       full;

    always_comb
    begin
        // window with the new byte appended
        for (int i = 0; i < 4; i++)
        begin
            w[i] = 8'h00;
            if (3'(i) == {1'b0, cnt_reg})
                w[i] = word.diff_byte;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (3'(i) < {1'b0, cnt_reg})
                w[i] = win_reg[i];
        end
        total    = {1'b0, cnt_reg} + 3'd1;
        full     = (cnt_reg == 2'd3);
        skip_sum = {w[0], w[1]} + {w[2], w[3]};

        d[0] = w[0];
        d[1] = w[1];
        dcnt = 2'd0;
        used = 3'd0;
        if (full)
        begin
            unique case (w[0][7:6])
                TOK_SINGLE:
                begin
                    dcnt = 2'd1;
                    if (w[1][7:6] == TOK_SINGLE && w[2][7:6] == TOK_SINGLE)
                    begin
                        d[0] = {TOK_PACKED, w[0][1:0], w[1][1:0], w[2][1:0]};
                        used = 3'd3;
                    end
                    else
                    begin
                        used = 3'd1;
                    end
                end
                TOK_SKIP:
                begin
                    dcnt = 2'd2;
                    // bit 13 of each skip word is bit 5 of its high byte
                    if (w[2][7:6] == TOK_SKIP && !w[0][5] && !w[2][5])
                    begin
                        d[0] = skip_sum[15:8];
                        d[1] = skip_sum[7:0];
                        used = 3'd4;
                    end
                    else
                    begin
                        used = 3'd2;
                    end
                end
                TOK_PACKED:
                begin
                    dcnt = 2'd1;
                    used = 3'd1;
                end
                TOK_INVALID:
                begin
                    used = 3'd1;
                end
                default:
                begin
                    used = 3'd1;
                end
            endcase
        end

        for (int i = 0; i < 3; i++)
        begin
            rem[i] = 8'h00;
            for (int j = 0; j < 4; j++)
            begin
                if (3'(j) == 3'(i) + used)
                    rem[i] = w[j];
            end
        end
        remn = total - used;

        // decision bytes first, then the leftover window on a flush
        for (int i = 0; i < 4; i++)
        begin
            cmd.bytes[i] = 8'h00;
            for (int j = 0; j < 3; j++)
            begin
                if (3'(i) == 3'(j) + {1'b0, dcnt})
                    cmd.bytes[i] = rem[j];
            end
            for (int j = 0; j < 2; j++)
            begin
                if (i == j && 2'(j) < dcnt)
                    cmd.bytes[i] = d[j];
            end
        end
        cmd.cnt  = word.end_of_list ? ({1'b0, dcnt} + remn) : {1'b0, dcnt};
        cmd.last = word.end_of_list;
        push     = accept && (cmd.cnt != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (accept)
            cnt_reg <= word.end_of_list ? 2'd0 : remn[1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
                win_reg[i] <= rem[i];
        end
    end

endmodule

// ----- rtl/core/dtm_queue.sv -----
module dtm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dtm_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output dtm_pkg::q_head_t head,
    output logic             full
);
    import dtm_pkg::*;

    cmd_t              mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- rtl/core/dtm_back.sv -----
module dtm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dtm_pkg::q_head_t  head,
    output logic              pop,
    output logic              dst_valid,
    input  logic              dst_stall,
    output dtm_pkg::out_word_t dst_word
);
    import dtm_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    out_word_t  word_reg;
    logic       load;
    logic       at_end;

    assign at_end    = ({1'b0, idx_reg} == head.cmd.cnt - 3'd1);
    assign load      = head.valid && (!valid_reg || !dst_stall);
    assign pop       = load && at_end;
    assign dst_valid = valid_reg;
    assign dst_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= at_end ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!dst_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg.out_byte <= head.cmd.bytes[idx_reg];
            word_reg.out_last <= head.cmd.last && at_end;
        end
    end

endmodule
